// ===== hw/rtl/bdf_pkg.sv =====
// Shared types and constants for the block data framer.
package bdf_pkg;

    // Buffer geometry
    localparam int BLOCK_BYTES = 256;
    localparam int ROWS        = (BLOCK_BYTES + 7) / 8;
    localparam int ROW_W       = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int FILL_W      = $clog2(BLOCK_BYTES + 1);
    localparam int POS_W       = (ROW_W + 3 > FILL_W) ? (ROW_W + 3) : FILL_W;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_TAG = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_TAG  = 8'd1;
    localparam logic [7:0] SHORT_TAG_RST = 8'd119;
    localparam logic [7:0] LONG_TAG_RST  = 8'd122;

    // Input kind codes
    localparam logic [1:0] KIND_APPEND = 2'd0;
    localparam logic [1:0] KIND_CHAR   = 2'd1;
    localparam logic [1:0] KIND_FLUSH  = 2'd2;
    localparam logic [1:0] KIND_MODE   = 2'd3;

    // Header lengths in bytes
    localparam logic [3:0] HDR_SHORT_LEN = 4'd2;
    localparam logic [3:0] HDR_LONG_LEN  = 4'd5;

    typedef enum logic [1:0] {
        OP_APPEND,
        OP_FLUSH,
        OP_MODE
    } op_t;

    // Classified command: bytes are left-aligned, first byte in bits 63:56
    typedef struct packed {
        op_t         op;
        logic [63:0] bytes;
        logic [3:0]  n;
        logic        mode;
    } cmd_t;

endpackage

// ===== hw/rtl/bdf_front.sv =====
// Front end: classifies input items and encodes characters into byte commands.
module bdf_front (
    input  logic               s_valid,
    input  logic [1:0]         s_kind,
    input  logic [63:0]        s_data_bytes,
    input  logic [3:0]         s_byte_count,
    input  logic [15:0]        s_char_code,
    input  logic               s_mode_value,
    output logic               push_valid,
    output bdf_pkg::cmd_t      push_cmd
);
    import bdf_pkg::*;

    logic [3:0]  app_n;
    logic [15:0] c;
    logic        drop;

    assign c = s_char_code;

    // Byte count clipped to eight
    assign app_n = (s_byte_count > 4'd8) ? 4'd8 : s_byte_count;

    // Appending nothing leaves no trace
    assign drop = (s_kind == KIND_APPEND) && (app_n == 4'd0);
    assign push_valid = s_valid && !drop;

    // Classification and modified UTF-8 encoding
    always_comb begin
        push_cmd.op    = OP_APPEND;
        push_cmd.bytes = '0;
        push_cmd.n     = 4'd0;
        push_cmd.mode  = s_mode_value;
        case (s_kind)
            KIND_APPEND: begin
                push_cmd.op    = OP_APPEND;
                push_cmd.n     = app_n;
                push_cmd.bytes = s_data_bytes << {4'(4'd8 - app_n), 3'b000};
            end
            KIND_CHAR: begin
                push_cmd.op = OP_APPEND;
                if (c >= 16'h0001 && c <= 16'h007F) begin
                    push_cmd.n     = 4'd1;
                    push_cmd.bytes = {c[7:0], 56'd0};
                end else if (c > 16'h07FF) begin
                    push_cmd.n     = 4'd3;
                    push_cmd.bytes = {8'hE0 | {4'd0, c[15:12]},
                                      8'h80 | {2'd0, c[11:6]},
                                      8'h80 | {2'd0, c[5:0]}, 40'd0};
                end else begin
                    // NUL and two-byte range
                    push_cmd.n     = 4'd2;
                    push_cmd.bytes = {8'hC0 | {3'd0, c[10:6]},
                                      8'h80 | {2'd0, c[5:0]}, 48'd0};
                end
            end
            KIND_FLUSH: begin
                push_cmd.op = OP_FLUSH;
            end
            KIND_MODE: begin
                push_cmd.op = OP_MODE;
            end
            default: begin
                push_cmd.op = OP_FLUSH;
            end
        endcase
    end

endmodule

// ===== hw/rtl/bdf_queue.sv =====
// Short command queue decoupling the front end from the back end.
module bdf_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push_valid,
    output logic               push_ready,
    input  bdf_pkg::cmd_t      push_cmd,
    output logic               pop_valid,
    input  logic               pop_ready,
    output bdf_pkg::cmd_t      pop_cmd
);
    import bdf_pkg::*;

    cmd_t               q_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               do_push, do_pop;

    assign push_ready = (count_reg != Q_CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = q_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            q_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/bdf_back.sv =====
// Back end: byte-lane block buffer, drain sequencer and result register.
module bdf_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  bdf_pkg::cmd_t      cmd,
    input  logic [7:0]         short_tag,
    input  logic [7:0]         long_tag,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [63:0]        m_out_word,
    output logic [3:0]         m_out_count,
    output logic               m_is_header,
    output logic               m_last
);
    import bdf_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WRITE,
        B_START,
        B_HDR,
        B_DATA
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic               mode_reg, mode_next;
    logic [63:0]        vec_reg, vec_next;
    logic [3:0]         rem_reg, rem_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               resume_reg, resume_next;
    logic               mode_apply_reg, mode_apply_next;
    logic               mode_val_reg, mode_val_next;

    logic               m_valid_reg, m_valid_next;
    logic [63:0]        word_reg, word_next;
    logic [3:0]         count_reg, count_next;
    logic               hdr_reg, hdr_next;
    logic               last_reg, last_next;

    // Buffer: eight byte lanes, row = position / 8, lane = position % 8
    logic [7:0]         mem [8][ROWS];
    logic [7:0]         rd_data [8];
    logic [7:0]         lane_we;
    logic [ROW_W-1:0]   lane_addr [8];
    logic [7:0]         lane_data [8];

    logic               out_free;
    logic [FILL_W-1:0]  space;
    logic [3:0]         wr_n;
    logic [POS_W-1:0]   remain;
    logic               word_last;
    logic [3:0]         word_cnt;
    logic [63:0]        data_word;
    logic [63:0]        hdr_word;
    logic [3:0]         hdr_cnt;

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == B_IDLE);

    // Bytes that fit before the buffer is full
    assign space = FILL_W'(BLOCK_BYTES) - fill_reg;
    assign wr_n  = (space < FILL_W'(rem_reg)) ? space[3:0] : rem_reg;

    // Lane write steering
    always_comb begin
        logic [2:0]       k;
        logic [POS_W-1:0] pos;
        for (int l = 0; l < 8; l++) begin
            k            = 3'(l) - fill_reg[2:0];
            pos          = POS_W'(fill_reg) + POS_W'(k);
            lane_we[l]   = (state_reg == B_WRITE) && (4'(k) < wr_n);
            lane_addr[l] = pos[ROW_W+2:3];
            lane_data[l] = vec_reg[{3'(3'd7 - k), 3'b000} +: 8];
        end
    end

    // Data word of the current row, unused bytes zero
    assign remain    = POS_W'(fill_reg) - POS_W'({row_reg, 3'b000});
    assign word_last = (remain <= POS_W'(8));
    assign word_cnt  = word_last ? remain[3:0] : 4'd8;

    always_comb begin
        for (int l = 0; l < 8; l++) begin
            data_word[63-8*l -: 8] = (4'(l) < word_cnt) ? rd_data[l] : 8'd0;
        end
    end

    // Header word: short or long length form
    always_comb begin
        if (fill_reg <= FILL_W'(255)) begin
            hdr_word = {short_tag, 8'(fill_reg), 48'd0};
            hdr_cnt  = HDR_SHORT_LEN;
        end else begin
            hdr_word = {long_tag, 32'(fill_reg), 24'd0};
            hdr_cnt  = HDR_LONG_LEN;
        end
    end

    // Sequencer next state
    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        mode_next       = mode_reg;
        vec_next        = vec_reg;
        rem_next        = rem_reg;
        row_next        = row_reg;
        resume_next     = resume_reg;
        mode_apply_next = mode_apply_reg;
        mode_val_next   = mode_val_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        word_next       = word_reg;
        count_next      = count_reg;
        hdr_next        = hdr_reg;
        last_next       = last_reg;
        case (state_reg)
            B_IDLE: begin
                if (cmd_valid) begin
                    resume_next     = 1'b0;
                    mode_apply_next = 1'b0;
                    case (cmd.op)
                        OP_APPEND: begin
                            vec_next   = cmd.bytes;
                            rem_next   = cmd.n;
                            state_next = B_WRITE;
                        end
                        OP_FLUSH: begin
                            if (fill_reg != '0) begin
                                state_next = B_START;
                            end
                        end
                        OP_MODE: begin
                            if (cmd.mode != mode_reg) begin
                                if (fill_reg != '0) begin
                                    mode_apply_next = 1'b1;
                                    mode_val_next   = cmd.mode;
                                    state_next      = B_START;
                                end else begin
                                    mode_next = cmd.mode;
                                end
                            end
                        end
                        default: begin
                            state_next = B_IDLE;
                        end
                    endcase
                end
            end
            B_WRITE: begin
                fill_next = fill_reg + FILL_W'(wr_n);
                vec_next  = vec_reg << {wr_n, 3'b000};
                rem_next  = rem_reg - wr_n;
                if (rem_reg == wr_n) begin
                    state_next = B_IDLE;
                end else begin
                    // A byte meets a full buffer: drain, then carry on writing
                    resume_next = 1'b1;
                    state_next  = B_START;
                end
            end
            B_START: begin
                row_next   = '0;
                state_next = mode_reg ? B_HDR : B_DATA;
            end
            B_HDR: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    word_next    = hdr_word;
                    count_next   = hdr_cnt;
                    hdr_next     = 1'b1;
                    last_next    = 1'b0;
                    state_next   = B_DATA;
                end
            end
            B_DATA: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    word_next    = data_word;
                    count_next   = word_cnt;
                    hdr_next     = 1'b0;
                    last_next    = word_last;
                    if (word_last) begin
                        fill_next  = '0;
                        state_next = resume_reg ? B_WRITE : B_IDLE;
                        if (mode_apply_reg) begin
                            mode_next = mode_val_reg;
                        end
                    end else begin
                        row_next = row_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // State and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= B_IDLE;
            fill_reg       <= '0;
            mode_reg       <= 1'b0;
            resume_reg     <= 1'b0;
            mode_apply_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            mode_reg       <= mode_next;
            vec_reg        <= vec_next;
            rem_reg        <= rem_next;
            row_reg        <= row_next;
            resume_reg     <= resume_next;
            mode_apply_reg <= mode_apply_next;
            mode_val_reg   <= mode_val_next;
            m_valid_reg    <= m_valid_next;
            word_reg       <= word_next;
            count_reg      <= count_next;
            hdr_reg        <= hdr_next;
            last_reg       <= last_next;
        end
    end

    // Buffer lanes: one write and one registered read per lane
    always_ff @(posedge aclk) begin
        for (int l = 0; l < 8; l++) begin
            if (lane_we[l]) begin
                mem[l][lane_addr[l]] <= lane_data[l];
            end
            rd_data[l] <= mem[l][row_next];
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_word  = word_reg;
    assign m_out_count = count_reg;
    assign m_is_header = hdr_reg;
    assign m_last      = last_reg;

endmodule

// ===== hw/rtl/block_data_framer_with_mutf8.sv =====
// Top level of the block data framer: configuration registers and block wiring.
//
// Items enter a two-deep command queue at up to one per cycle while it has room;
// characters are turned into modified UTF-8 bytes on the way in. The back end
// takes one command at a time: an append is taken in the idle state and all its
// bytes are then written at once into the eight byte-lane buffer; a flush or
// mode change with nothing buffered ends on being taken. A drain passes through
// a set-up state, a header word in block mode, and one data word per eight
// buffered bytes, read row by row through the single read port of the buffer
// into the result register. An append that meets a full buffer drains it and
// then goes back to writing the rest of its bytes. Back-pressure on the result
// channel stalls the drain. Configuration writes are taken at any time and
// should be made while the block is idle.
module block_data_framer_with_mutf8 (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic [63:0]                    s_data_bytes,
    input  logic [3:0]                     s_byte_count,
    input  logic [15:0]                    s_char_code,
    input  logic                           s_mode_value,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [63:0]                    m_out_word,
    output logic [3:0]                     m_out_count,
    output logic                           m_is_header,
    output logic                           m_last
);
    import bdf_pkg::*;

    logic [7:0] short_tag_reg, short_tag_next;
    logic [7:0] long_tag_reg, long_tag_next;
    logic       push_valid, push_ready;
    cmd_t       push_cmd;
    logic       pop_valid, pop_ready;
    cmd_t       pop_cmd;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        short_tag_next = short_tag_reg;
        long_tag_next  = long_tag_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_SHORT_TAG: short_tag_next = cfg_data;
                REG_LONG_TAG:  long_tag_next  = cfg_data;
                default:       short_tag_next = short_tag_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            short_tag_reg <= SHORT_TAG_RST;
            long_tag_reg  <= LONG_TAG_RST;
        end else begin
            short_tag_reg <= short_tag_next;
            long_tag_reg  <= long_tag_next;
        end
    end

    // Input transfer accepted whenever the queue has room
    assign s_ready = push_ready;

    bdf_front u_front (
        .s_valid      (s_valid),
        .s_kind       (s_kind),
        .s_data_bytes (s_data_bytes),
        .s_byte_count (s_byte_count),
        .s_char_code  (s_char_code),
        .s_mode_value (s_mode_value),
        .push_valid   (push_valid),
        .push_cmd     (push_cmd)
    );

    bdf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    bdf_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd_valid   (pop_valid),
        .cmd_ready   (pop_ready),
        .cmd         (pop_cmd),
        .short_tag   (short_tag_reg),
        .long_tag    (long_tag_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_word  (m_out_word),
        .m_out_count (m_out_count),
        .m_is_header (m_is_header),
        .m_last      (m_last)
    );

endmodule

// ===== bench/bdf_frame_checker.sv =====
// Checker for the block data framer: predicts output words and compares them.
`timescale 1ns / 100ps

module bdf_frame_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    input  logic                           cfg_ready,
    input  logic [bdf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [7:0]                     cfg_data,
    input  logic                           s_valid,
    input  logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic [63:0]                    s_data_bytes,
    input  logic [3:0]                     s_byte_count,
    input  logic [15:0]                    s_char_code,
    input  logic                           s_mode_value,
    input  logic                           m_valid,
    input  logic                           m_ready,
    input  logic [63:0]                    m_out_word,
    input  logic [3:0]                     m_out_count,
    input  logic                           m_is_header,
    input  logic                           m_last,
    output int                             errors,
    output int                             pending,
    output int                             words_seen,
    output int                             headers_seen
);
    import bdf_pkg::*;

    // Modified UTF-8 lead and continuation prefixes
    localparam logic [7:0] UTF_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF_CONT  = 8'h80;

    typedef struct packed {
        logic [63:0] word;
        logic [3:0]  count;
        logic        header;
        logic        last;
    } frame_word_t;

    frame_word_t              expected_words[$];
    logic [7:0]               frame_buf[BLOCK_BYTES];
    logic [FILL_W-1:0]        fill_level;
    logic                     framed;
    logic [7:0]               short_tag;
    logic [7:0]               long_tag;

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s of word %0d: got %h, expected %h",
                 $time, field, words_seen, got, want);
        errors++;
    endtask

    // Emit the buffered bytes, with a header in framed mode
    task automatic drain_frame();
        frame_word_t w;
        int pos;
        int cnt;
        if (fill_level == 0) return;
        if (framed) begin
            w = '0;
            w.header = 1'b1;
            if (fill_level <= 255) begin
                w.word  = {short_tag, fill_level[7:0], 48'h0};
                w.count = HDR_SHORT_LEN;
            end else begin
                w.word  = {long_tag, 32'(fill_level), 24'h0};
                w.count = HDR_LONG_LEN;
            end
            expected_words.push_back(w);
        end
        for (pos = 0; pos < int'(fill_level); pos += 8) begin
            w = '0;
            cnt = (int'(fill_level) - pos < 8) ? int'(fill_level) - pos : 8;
            for (int j = 0; j < cnt; j++)
                w.word[63-8*j -: 8] = frame_buf[pos+j];
            w.count = 4'(cnt);
            expected_words.push_back(w);
        end
        fill_level = '0;
    endtask

    // A byte meeting a full buffer drains it first
    task automatic push_byte(input logic [7:0] b);
        if (fill_level >= BLOCK_BYTES) drain_frame();
        if (fill_level < BLOCK_BYTES) begin
            frame_buf[fill_level] = b;
            fill_level++;
        end
    endtask

    task automatic predict_item(input logic [1:0] kind, input logic [63:0] data,
                                input logic [3:0] count, input logic [15:0] code,
                                input logic mode);
        int prior_words;
        int n;
        frame_word_t tail;
        prior_words = expected_words.size();
        case (kind)
            KIND_APPEND: begin
                n = (count > 4'd8) ? 8 : int'(count);
                for (int k = n; k > 0; k--)
                    push_byte(data[8*(k-1) +: 8]);
            end
            KIND_CHAR: begin
                if (code >= 16'h0001 && code <= 16'h007F) begin
                    push_byte(code[7:0]);
                end else if (code > 16'h07FF) begin
                    push_byte(UTF_LEAD3 | {4'h0, code[15:12]});
                    push_byte(UTF_CONT | {2'b00, code[11:6]});
                    push_byte(UTF_CONT | {2'b00, code[5:0]});
                end else begin
                    push_byte(UTF_LEAD2 | {3'b000, code[10:6]});
                    push_byte(UTF_CONT | {2'b00, code[5:0]});
                end
            end
            KIND_FLUSH: drain_frame();
            default: begin
                // mode change drains under the old mode
                if (mode != framed) begin
                    drain_frame();
                    framed = mode;
                end
            end
        endcase
        if (expected_words.size() > prior_words) begin
            tail = expected_words.pop_back();
            tail.last = 1'b1;
            expected_words.push_back(tail);
        end
    endtask

    task automatic check_word();
        frame_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected transfer", m_out_word, 64'h0);
        end else begin
            want = expected_words.pop_front();
            if (m_out_word !== want.word)
                report_mismatch("out_word", m_out_word, want.word);
            if (m_out_count !== want.count)
                report_mismatch("out_count", 64'(m_out_count), 64'(want.count));
            if (m_is_header !== want.header)
                report_mismatch("is_header", 64'(m_is_header), 64'(want.header));
            if (m_last !== want.last)
                report_mismatch("last", 64'(m_last), 64'(want.last));
        end
        words_seen++;
        if (m_is_header === 1'b1) headers_seen++;
    endtask

    initial begin
        errors       = 0;
        pending      = 0;
        words_seen   = 0;
        headers_seen = 0;
    end

    // Watch all three channels on the rising edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_words.delete();
            fill_level = '0;
            framed     = 1'b0;
            short_tag  = SHORT_TAG_RST;
            long_tag   = LONG_TAG_RST;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == REG_SHORT_TAG)
                    short_tag = cfg_data;
                else if (cfg_index == REG_LONG_TAG)
                    long_tag = cfg_data;
            end
            if (m_valid && m_ready) check_word();
            if (s_valid && s_ready)
                predict_item(s_kind, s_data_bytes, s_byte_count, s_char_code,
                             s_mode_value);
        end
        pending = expected_words.size();
    end

endmodule

// ===== bench/block_data_framer_with_mutf8_test.sv =====
// Testbench top for the block data framer: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module block_data_framer_with_mutf8_test;
    import bdf_pkg::*;

    localparam logic MODE_RAW     = 1'b0;
    localparam logic MODE_FRAMED  = 1'b1;
    localparam int   SETTLE       = 40;     // worst drain plus queue, in cycles
    localparam int   HOLD_CYCLES  = 400;
    localparam int   RANDOM_ITEMS = 230;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [7:0]            cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_kind;
    logic [63:0]           s_data_bytes;
    logic [3:0]            s_byte_count;
    logic [15:0]           s_char_code;
    logic                  s_mode_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [63:0]           m_out_word;
    logic [3:0]            m_out_count;
    logic                  m_is_header;
    logic                  m_last;

    int   errors;
    int   pending;
    int   words_seen;
    int   headers_seen;
    int   useful_items;
    int   directed_items;
    logic cur_mode;
    bit   tx_steady;
    bit   rx_steady;
    bit   hold_request;

    block_data_framer_with_mutf8 DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_data_bytes (s_data_bytes),
        .s_byte_count (s_byte_count),
        .s_char_code  (s_char_code),
        .s_mode_value (s_mode_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_word   (m_out_word),
        .m_out_count  (m_out_count),
        .m_is_header  (m_is_header),
        .m_last       (m_last)
    );

    bdf_frame_checker CHECK (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_data_bytes (s_data_bytes),
        .s_byte_count (s_byte_count),
        .s_char_code  (s_char_code),
        .s_mode_value (s_mode_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_word   (m_out_word),
        .m_out_count  (m_out_count),
        .m_is_header  (m_is_header),
        .m_last       (m_last),
        .errors       (errors),
        .pending      (pending),
        .words_seen   (words_seen),
        .headers_seen (headers_seen)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 2);
        if (r < 95) return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    // Spread character codes over the one, two and three byte encodings
    function automatic logic [15:0] rand_code();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'h0000;
        if (r < 7)  return 16'($urandom_range(16'h0001, 16'h007F));
        if (r < 13) return 16'($urandom_range(16'h0080, 16'h07FF));
        return 16'($urandom_range(16'h0800, 16'hFFFF));
    endfunction

    // One input transfer; called and returns on a falling edge
    task automatic send_item(input logic [1:0] kind, input logic [63:0] data,
                             input logic [3:0] cnt, input logic [15:0] code,
                             input logic mode);
        bit counted;
        int gap;
        counted = 1'b1;
        s_valid      <= 1'b1;
        s_kind       <= kind;
        s_data_bytes <= data;
        s_byte_count <= cnt;
        s_char_code  <= code;
        s_mode_value <= mode;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (kind == KIND_MODE) begin
            if (mode == cur_mode) counted = 1'b0;
            cur_mode = mode;
        end else if (kind == KIND_APPEND && cnt == 4'd0) begin
            counted = 1'b0;
        end
        if (counted) useful_items++;
        if (!tx_steady && $urandom_range(0, 99) < 30) begin
            gap = pick_gap();
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic append_item(input logic [3:0] cnt);
        send_item(KIND_APPEND, {$urandom, $urandom}, cnt, 16'($urandom), 1'($urandom));
    endtask

    task automatic char_item(input logic [15:0] code);
        send_item(KIND_CHAR, {$urandom, $urandom}, 4'($urandom), code, 1'($urandom));
    endtask

    task automatic flush_item();
        send_item(KIND_FLUSH, {$urandom, $urandom}, 4'($urandom), 16'($urandom),
                  1'($urandom));
    endtask

    task automatic mode_item(input logic mode);
        send_item(KIND_MODE, {$urandom, $urandom}, 4'($urandom), 16'($urandom), mode);
    endtask

    task automatic rand_item(input logic [1:0] kind);
        int r;
        case (kind)
            KIND_APPEND: begin
                r = $urandom_range(0, 19);
                if (r == 0)     append_item(4'd0);
                else if (r < 3) append_item(4'($urandom_range(9, 15)));
                else            append_item(4'($urandom_range(1, 8)));
            end
            KIND_CHAR:  char_item(rand_code());
            KIND_FLUSH: flush_item();
            default:    mode_item(1'($urandom));
        endcase
    endtask

    // End a sequence with a flush or a mode toggle, both of which drain
    task automatic close_seq();
        if ($urandom_range(0, 1)) flush_item();
        else                      mode_item(~cur_mode);
    endtask

    task automatic burst_seq();
        int n;
        n = $urandom_range(1, 12);
        repeat (n) rand_item($urandom_range(0, 9) < 6 ? KIND_APPEND : KIND_CHAR);
        close_seq();
    endtask

    task automatic noise_seq();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) rand_item(2'($urandom_range(0, 3)));
    endtask

    // Fill the buffer to an exact length, then drain it
    task automatic exact_fill_seq(input int len);
        flush_item();
        repeat (len / 8) append_item(4'd8);
        if (len % 8 != 0) append_item(4'(len % 8));
        close_seq();
    endtask

    // Run past a full buffer so that a byte meets it and forces the drain
    task automatic overflow_seq();
        int bytes;
        int cnt;
        logic [15:0] code;
        flush_item();
        bytes = 0;
        while (bytes < 300) begin
            if ($urandom_range(0, 3) != 0) begin
                cnt = $urandom_range(1, 8);
                append_item(4'(cnt));
                bytes += cnt;
            end else begin
                code = rand_code();
                char_item(code);
                if (code == 16'h0000 || (code > 16'h007F && code <= 16'h07FF)) bytes += 2;
                else if (code > 16'h07FF) bytes += 3;
                else bytes += 1;
            end
        end
        close_seq();
    endtask

    // Sender pause until every expected word has come back
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_tags(input logic [7:0] short_value, input logic [7:0] long_value);
        write_reg(REG_SHORT_TAG, short_value);
        write_reg(REG_LONG_TAG, long_value);
    endtask

    task automatic random_phase(input int until_items);
        while (useful_items < until_items) begin
            tx_steady = ($urandom_range(0, 4) == 0);
            rx_steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 3) == 0) noise_seq();
            else                           burst_seq();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                stall = pick_gap();
                repeat (stall) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Generous overall limit
    initial begin
        #5_000_000;
        $display("Timeout with %0d words still expected", pending);
        $display("** block_data_framer_with_mutf8: FAILED **");
        $finish;
    end

    // Stimulus
    initial begin
        int spin;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_kind       = KIND_APPEND;
        s_data_bytes = '0;
        s_byte_count = '0;
        s_char_code  = '0;
        s_mode_value = MODE_RAW;
        useful_items = 0;
        cur_mode     = MODE_RAW;
        tx_steady    = 1'b0;
        rx_steady    = 1'b0;
        hold_request = 1'b0;
        repeat (3) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Directed: field extremes, every kind, every encoding class, reset tags
        mode_item(MODE_RAW);                                  // same mode
        flush_item();                                         // empty drain
        send_item(KIND_APPEND, '1, 4'd0, 16'hFFFF, MODE_FRAMED);
        send_item(KIND_APPEND, 64'h0, 4'd1, 16'hFFFF, MODE_FRAMED);
        send_item(KIND_APPEND, '1, 4'd8, 16'h0000, MODE_RAW);
        send_item(KIND_APPEND, 64'h0123_4567_89AB_CDEF, 4'hF, 16'h0000, MODE_RAW);
        char_item(16'h0000);
        char_item(16'h0001);
        char_item(16'h007F);
        char_item(16'h0080);
        char_item(16'h07FF);
        char_item(16'h0800);
        char_item(16'hFFFF);
        flush_item();                                         // raw drain
        mode_item(MODE_FRAMED);                               // switch, nothing held
        mode_item(MODE_FRAMED);
        append_item(4'd3);
        flush_item();                                         // short header
        append_item(4'd5);
        char_item(16'h1234);
        mode_item(MODE_RAW);                                  // drains framed
        mode_item(MODE_FRAMED);
        send_item(KIND_APPEND, 64'h0, 4'd8, 16'h0000, MODE_RAW);
        flush_item();
        directed_items = useful_items;
        wait_idle();

        // Extreme tags; longest short block and a full buffer
        set_tags(8'h00, 8'hFF);
        mode_item(MODE_FRAMED);
        exact_fill_seq(255);
        mode_item(MODE_FRAMED);
        exact_fill_seq(256);
        random_phase(directed_items + 80);
        wait_idle();

        // Swapped extremes; receiver holds off while the buffer overflows
        set_tags(8'hFF, 8'h00);
        mode_item(MODE_FRAMED);
        hold_request = 1'b1;
        overflow_seq();
        random_phase(directed_items + 160);
        wait_idle();

        // Random tags
        set_tags(8'($urandom), 8'($urandom));
        mode_item(MODE_FRAMED);
        overflow_seq();
        random_phase(directed_items + RANDOM_ITEMS);
        s_valid <= 1'b0;

        for (spin = 0; spin < 200_000 && pending != 0; spin++) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);

        $display("Ran %0d effective items (%0d directed) under four tag settings;",
                 useful_items, directed_items);
        $display("checked %0d output words, %0d of them block headers.",
                 words_seen, headers_seen);
        if (errors == 0 && pending == 0) begin
            $display("** block_data_framer_with_mutf8: PASSED **");
        end else begin
            $display("%0d mismatches, %0d words never arrived", errors, pending);
            $display("** block_data_framer_with_mutf8: FAILED **");
        end
        $finish;
    end

endmodule
